FILE: rtl/core/lfsr_scr_pkg.sv
// shared types, codes and helpers for the lfsr keystream scrambler
package lfsr_scr_pkg;

    localparam int LFSR_W     = 24;
    localparam int WORD_W     = 64;
    localparam int FRAME_BITS = 128;
    localparam int FRAME_SH   = 7;
    localparam int FRAMES_W   = 16;
    localparam int CNT_W      = FRAMES_W + FRAME_SH;

    typedef enum logic [1:0] {
        FUNC_RELOAD   = 2'd0,
        FUNC_SEEK     = 2'd1,
        FUNC_GENERATE = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        TAPS_8    = 2'd0,
        TAPS_16   = 2'd1,
        TAPS_24   = 2'd2,
        TAPS_AUTO = 2'd3
    } taps_t;

    typedef enum logic [1:0] {
        CFG_KEY     = 2'd0,
        CFG_SUB_ENC = 2'd1,
        CFG_SUB_DEC = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT_HI,
        ST_EMIT_LO
    } lfsr_scr_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic emit;
        logic emit_last;
    } lfsr_scr_ctl_t;

    function automatic taps_t resolve_taps(input taps_t sel, input logic [LFSR_W-1:0] key);
        taps_t res;
        if (sel != TAPS_AUTO) begin
            res = sel;
        end else if (key[23:16] != 8'd0) begin
            res = TAPS_24;
        end else if (key[15:8] != 8'd0) begin
            res = TAPS_16;
        end else begin
            res = TAPS_8;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/selectable_lfsr_keystream_scrambler.sv
// top level of the selectable lfsr keystream scrambler
//
// Input words arrive on the s_ channel: s_tuser carries the operation and the
// direction (decode or encode register), s_tdata the frame number for a seek.
// Results leave on the m_ channel: m_tdata holds 64 keystream bits and the
// register contents after the operation, m_tuser the resolved tap set and
// m_tlast marks the final word of an operation. Configuration (key and the two
// tap-set selectors) is written through cfg_valid/cfg_index/cfg_data and is
// always ready; write it only while the block is idle.
// The register advances one step per cycle through a single shared step unit.
// A reload or an unused code runs no steps; a seek steps the key through
// frame_number whole frames and a generate steps the stored register through
// one frame. The sequencer then commits the register and emits each word
// into the output register, a generate's second as soon as the first is
// taken. One operation is in flight at a time; s_tready returns once the last
// word sits in the output register, so a new word is accepted while that
// result still waits to be taken. A stalled receiver holds the output register
// and the sequencer until it is free.
// After reset both registers are zero, the key is zero and both selectors are
// set to automatic.
module selectable_lfsr_keystream_scrambler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // frame_number[15:0]
    input  logic [2:0]  s_tuser,   // func[1:0], direction[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pn_bits[63:0], seed_now[87:64]
    output logic [1:0]  m_tuser,   // subtype_used[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import lfsr_scr_pkg::*;

    lfsr_scr_ctl_t ctl;

    logic [LFSR_W-1:0]       key_reg;
    taps_t                   sub_enc_reg, sub_dec_reg;
    logic [LFSR_W-1:0]       lfsr_reg [2];
    logic [LFSR_W-1:0]       work_reg;
    logic [FRAME_BITS-1:0]   pn_reg;
    taps_t                   taps_reg;
    logic                    dir_reg;
    logic                    gen_reg;

    logic                    out_valid_reg;
    logic [WORD_W-1:0]       out_pn_reg;
    logic [LFSR_W-1:0]       out_seed_reg;
    taps_t                   out_taps_reg;
    logic                    out_last_reg;

    func_t                   in_func;
    logic                    in_dir;
    taps_t                   in_taps;
    logic [LFSR_W-1:0]       step_out;
    logic                    fb_bit;
    logic                    out_free;
    logic [WORD_W-1:0]       emit_pn;

    assign in_func   = func_t'(s_tuser[1:0]);
    assign in_dir    = s_tuser[2];
    assign in_taps   = resolve_taps(in_dir ? sub_enc_reg : sub_dec_reg, key_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    lfsr_scr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_func   (in_func),
        .in_frames (s_tdata),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .ctl       (ctl)
    );

    lfsr_scr_step u_step (
        .state_in  (work_reg),
        .taps      (taps_reg),
        .state_out (step_out),
        .fb_bit    (fb_bit)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            sub_enc_reg <= TAPS_AUTO;
            sub_dec_reg <= TAPS_AUTO;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY:     key_reg     <= cfg_data;
                CFG_SUB_ENC: sub_enc_reg <= taps_t'(cfg_data[1:0]);
                CFG_SUB_DEC: sub_dec_reg <= taps_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // stored registers per direction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg[0] <= '0;
            lfsr_reg[1] <= '0;
        end else if (ctl.commit) begin
            lfsr_reg[dir_reg] <= work_reg;
        end
    end

    // working register and keystream shift line
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            work_reg <= (in_func == FUNC_RELOAD || in_func == FUNC_SEEK) ?
                        key_reg : lfsr_reg[in_dir];
            taps_reg <= in_taps;
            dir_reg  <= in_dir;
            gen_reg  <= (in_func == FUNC_GENERATE);
        end else if (ctl.step) begin
            work_reg <= step_out;
            pn_reg   <= {pn_reg[FRAME_BITS-2:0], fb_bit};
        end
    end

    always_comb begin
        if (!gen_reg) begin
            emit_pn = '0;
        end else if (ctl.emit_last) begin
            emit_pn = pn_reg[WORD_W-1:0];
        end else begin
            emit_pn = pn_reg[FRAME_BITS-1:WORD_W];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            out_pn_reg   <= emit_pn;
            out_seed_reg <= work_reg;
            out_taps_reg <= taps_reg;
            out_last_reg <= ctl.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_seed_reg, out_pn_reg};
    assign m_tuser  = out_taps_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/core/lfsr_scr_step.sv
// single fibonacci lfsr step with selectable tap set
module lfsr_scr_step (
    input  logic [lfsr_scr_pkg::LFSR_W-1:0] state_in,
    input  lfsr_scr_pkg::taps_t             taps,
    output logic [lfsr_scr_pkg::LFSR_W-1:0] state_out,
    output logic                            fb_bit
);
    import lfsr_scr_pkg::*;

    always_comb begin
        unique case (taps)
            TAPS_8:  fb_bit = state_in[7] ^ state_in[5] ^ state_in[4] ^ state_in[3];
            TAPS_16: fb_bit = state_in[15] ^ state_in[14] ^ state_in[12] ^ state_in[3];
            default: fb_bit = state_in[23] ^ state_in[22] ^ state_in[21] ^ state_in[16];
        endcase
    end

    assign state_out = {state_in[LFSR_W-2:0], fb_bit};

endmodule

FILE: rtl/core/lfsr_scr_ctrl.sv
// sequencer: step counter and state machine for one operation
module lfsr_scr_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  lfsr_scr_pkg::func_t            in_func,
    input  logic [lfsr_scr_pkg::FRAMES_W-1:0] in_frames,
    input  logic                           out_free,
    output logic                           in_ready,
    output lfsr_scr_pkg::lfsr_scr_ctl_t    ctl
);
    import lfsr_scr_pkg::*;

    lfsr_scr_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             gen_reg, gen_next;
    logic [CNT_W-1:0] load_cnt;

    always_comb begin
        unique case (in_func)
            FUNC_GENERATE: load_cnt = CNT_W'(FRAME_BITS);
            FUNC_SEEK:     load_cnt = {in_frames, FRAME_SH'(0)};
            default:       load_cnt = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (cnt_reg == '0) state_next = gen_reg ? ST_EMIT_HI : ST_EMIT_LO;
            end
            ST_EMIT_HI: begin
                if (out_free) state_next = ST_EMIT_LO;
            end
            ST_EMIT_LO: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctl      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_RUN: begin
                ctl.step   = (cnt_reg != '0);
                ctl.commit = (cnt_reg == '0);
            end
            ST_EMIT_HI: begin
                ctl.emit = out_free;
            end
            ST_EMIT_LO: begin
                ctl.emit      = out_free;
                ctl.emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        gen_next = gen_reg;
        if (ctl.load) begin
            cnt_next = load_cnt;
            gen_next = (in_func == FUNC_GENERATE);
        end else if (ctl.step) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            gen_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            gen_reg   <= gen_next;
        end
    end

endmodule

FILE: rtl/core/lfsr_scr_checker.sv
// port-level checks for the lfsr keystream scrambler and their binding
module lfsr_scr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import lfsr_scr_pkg::*;

    // output register empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("word valid right after reset");

    // stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled word changed");

    // second keystream word follows the first at once
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("final word missing after first keystream word");

    // no new operation while a first keystream word is pending
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready mid-frame");

    // resolved tap set is never the automatic code
    a_taps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != TAPS_AUTO)
        else $error("unresolved tap set on output");

endmodule

bind selectable_lfsr_keystream_scrambler lfsr_scr_checker u_lfsr_scr_checker (.*);

FILE: test/selectable_lfsr_keystream_scrambler_tb.sv
// self-checking testbench for the lfsr keystream scrambler: directed and random words, stalls
module selectable_lfsr_keystream_scrambler_tb;
    import lfsr_scr_pkg::*;

    typedef struct {
        func_t       op;
        logic        dir;
        logic [15:0] frames;
    } scr_cmd_t;

    typedef struct {
        logic [63:0] pn;
        logic [23:0] seed;
        taps_t       taps;
        logic        last;
    } scr_word_t;

    localparam int STALL_LIMIT = 800_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    scr_cmd_t    cmd_queue[$];
    scr_word_t   keystream_due[$];
    scr_cmd_t    cur_cmd;
    int          gap_pct = 30;
    int          n_errors = 0;
    int          quiet_cycles = 0;

    logic [23:0] key_q = '0;
    taps_t       sub_enc_q = TAPS_AUTO;
    taps_t       sub_dec_q = TAPS_AUTO;
    logic [23:0] lfsr_q[2] = '{24'd0, 24'd0};

    selectable_lfsr_keystream_scrambler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic taps_t pick_taps(input taps_t sel);
        taps_t t;
        if (sel != TAPS_AUTO) begin
            t = sel;
        end else if (key_q > 24'hFFFF) begin
            t = TAPS_24;
        end else if (key_q > 24'hFF) begin
            t = TAPS_16;
        end else begin
            t = TAPS_8;
        end
        return t;
    endfunction

    function automatic logic [23:0] lfsr_advance(input logic [23:0] r, input taps_t t);
        logic fb;
        case (t)
            TAPS_8:  fb = r[7] ^ r[5] ^ r[4] ^ r[3];
            TAPS_16: fb = r[15] ^ r[14] ^ r[12] ^ r[3];
            default: fb = r[23] ^ r[22] ^ r[21] ^ r[16];
        endcase
        return {r[22:0], fb};
    endfunction

    function automatic void predict_scramble(input scr_cmd_t c);
        taps_t        t;
        logic [23:0]  r;
        logic [127:0] ks;
        int           n;
        t  = pick_taps(c.dir ? sub_enc_q : sub_dec_q);
        r  = lfsr_q[c.dir];
        ks = '0;
        case (c.op)
            FUNC_GENERATE: begin
                for (n = 0; n < FRAME_BITS; n++) begin
                    r  = lfsr_advance(r, t);
                    ks = {ks[126:0], r[0]};
                end
                lfsr_q[c.dir] = r;
                keystream_due.push_back('{ks[127:64], r, t, 1'b0});
                keystream_due.push_back('{ks[63:0], r, t, 1'b1});
            end
            FUNC_RELOAD: begin
                lfsr_q[c.dir] = key_q;
                keystream_due.push_back('{64'd0, key_q, t, 1'b1});
            end
            FUNC_SEEK: begin
                r = key_q;
                for (n = 0; n < int'(c.frames) * FRAME_BITS; n++) begin
                    r = lfsr_advance(r, t);
                end
                lfsr_q[c.dir] = r;
                keystream_due.push_back('{64'd0, r, t, 1'b1});
            end
            default: begin
                keystream_due.push_back('{64'd0, r, t, 1'b1});
            end
        endcase
    endfunction

    function automatic void add_cmd(input func_t op, input logic dir, input logic [15:0] frames);
        cmd_queue.push_back('{op, dir, frames});
    endfunction

    function automatic scr_cmd_t rand_cmd();
        scr_cmd_t c;
        int       pick;
        pick     = $urandom_range(99);
        c.dir    = 1'($urandom_range(1));
        c.frames = 16'($urandom);
        if (pick < 40) begin
            c.op = FUNC_GENERATE;
        end else if (pick < 65) begin
            c.op     = FUNC_SEEK;
            c.frames = ($urandom_range(31) == 0) ? 16'($urandom_range(255))
                                                 : 16'($urandom_range(7));
        end else if (pick < 90) begin
            c.op = FUNC_RELOAD;
        end else begin
            c.op = FUNC_UNUSED;
        end
        return c;
    endfunction

    function automatic logic [23:0] rand_key();
        logic [23:0] k;
        case ($urandom_range(3))
            0:       k = 24'($urandom_range(255));
            1:       k = 24'($urandom_range(256, 65535));
            2:       k = 24'($urandom_range(65536, 24'hFFFFFF));
            default: k = 24'($urandom);
        endcase
        return k;
    endfunction

    task automatic set_reg(input cfg_idx_t idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY:     key_q = val;
            CFG_SUB_ENC: sub_enc_q = taps_t'(val[1:0]);
            CFG_SUB_DEC: sub_dec_q = taps_t'(val[1:0]);
            default: ;
        endcase
    endtask

    // checked between edges so that the driver has settled
    task automatic wait_drained();
        @(negedge aclk);
        while (cmd_queue.size() != 0 || s_tvalid || keystream_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_scramble(cur_cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_cmd.frames;
                    s_tuser  <= {cur_cmd.dir, cur_cmd.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        scr_word_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (keystream_due.size() == 0) begin
                    $error("result word with nothing expected");
                    n_errors++;
                end else begin
                    w = keystream_due.pop_front();
                    if (m_tdata[63:0] !== w.pn) begin
                        $error("pn_bits: expected %h, got %h", w.pn, m_tdata[63:0]);
                        n_errors++;
                    end
                    if (m_tdata[87:64] !== w.seed) begin
                        $error("seed_now: expected %h, got %h", w.seed, m_tdata[87:64]);
                        n_errors++;
                    end
                    if (m_tuser !== w.taps) begin
                        $error("subtype_used: expected %0d, got %0d", w.taps, m_tuser);
                        n_errors++;
                    end
                    if (m_tlast !== w.last) begin
                        $error("last: expected %0d, got %0d", w.last, m_tlast);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || (cmd_queue.size() == 0 && !s_tvalid && keystream_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[selectable_lfsr_keystream_scrambler] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph;
        int k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: zero key, zero registers, automatic taps
        add_cmd(FUNC_GENERATE, 1'b0, 16'h0000);
        add_cmd(FUNC_GENERATE, 1'b1, 16'hFFFF);
        add_cmd(FUNC_SEEK, 1'b1, 16'd5);
        add_cmd(FUNC_RELOAD, 1'b0, 16'hFFFF);
        add_cmd(FUNC_UNUSED, 1'b0, 16'hFFFF);
        wait_drained();

        set_reg(CFG_KEY, 24'h0000A5);
        set_reg(CFG_NONE, 24'h000001);
        add_cmd(FUNC_RELOAD, 1'b0, 16'h0000);
        add_cmd(FUNC_GENERATE, 1'b0, 16'hFFFF);
        add_cmd(FUNC_GENERATE, 1'b0, 16'h0000);
        add_cmd(FUNC_SEEK, 1'b1, 16'd0);
        add_cmd(FUNC_SEEK, 1'b1, 16'd1);
        add_cmd(FUNC_GENERATE, 1'b1, 16'h0000);
        add_cmd(FUNC_UNUSED, 1'b1, 16'h0000);
        wait_drained();

        set_reg(CFG_KEY, 24'h00FFFF);
        set_reg(CFG_SUB_ENC, 24'(TAPS_8));
        set_reg(CFG_SUB_DEC, 24'(TAPS_24));
        add_cmd(FUNC_RELOAD, 1'b0, 16'h0000);
        add_cmd(FUNC_RELOAD, 1'b1, 16'h0000);
        add_cmd(FUNC_GENERATE, 1'b0, 16'h0000);
        add_cmd(FUNC_GENERATE, 1'b1, 16'h0000);
        add_cmd(FUNC_SEEK, 1'b0, 16'd3);
        wait_drained();

        set_reg(CFG_KEY, 24'hFFFFFF);
        set_reg(CFG_SUB_ENC, 24'(TAPS_16));
        set_reg(CFG_SUB_DEC, 24'(TAPS_AUTO));
        add_cmd(FUNC_SEEK, 1'b1, 16'd1500);
        add_cmd(FUNC_GENERATE, 1'b1, 16'h0000);
        add_cmd(FUNC_SEEK, 1'b0, 16'd7);
        add_cmd(FUNC_GENERATE, 1'b0, 16'h0000);
        wait_drained();

        set_reg(CFG_KEY, 24'h000100);
        set_reg(CFG_SUB_ENC, 24'(TAPS_AUTO));
        add_cmd(FUNC_RELOAD, 1'b1, 16'h0000);
        add_cmd(FUNC_GENERATE, 1'b1, 16'h0000);
        wait_drained();

        for (ph = 0; ph < 7; ph++) begin
            gap_pct = (ph == 3) ? 0 : 30;
            set_reg(CFG_KEY, rand_key());
            set_reg(CFG_SUB_ENC, 24'($urandom_range(3)));
            set_reg(CFG_SUB_DEC, 24'($urandom_range(3)));
            for (k = 0; k < 150; k++) begin
                cmd_queue.push_back(rand_cmd());
            end
            wait_drained();
        end

        if (keystream_due.size() != 0) begin
            $error("%0d result words never arrived", keystream_due.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("[selectable_lfsr_keystream_scrambler] OK");
        end else begin
            $display("[selectable_lfsr_keystream_scrambler] ERROR");
        end
        $finish;
    end

endmodule
